FILE: src/orbcam_pkg.sv
// Shared types, constants and trig helpers for the orbit camera basis update.
// Used by every module of the block; depends on nothing else.
package orbcam_pkg;

    localparam int unsigned SINE_TABLE_ENTRIES = 91;

    localparam logic signed [7:0] C_ELEV_LIMIT = 8'sd89;
    localparam logic signed [7:0] C_ELEV_RESET = 8'sd45;
    localparam logic [8:0]        C_HEAD_RESET = 9'd90;
    localparam logic [15:0]       C_DIST_RESET = 16'd5120;
    localparam logic [16:0]       C_DEG_TURN   = 17'd360;
    localparam logic [16:0]       C_WRAP_BIAS  = 17'd92160;
    localparam logic [2:0]        C_WRAP_STEPS = 3'd7;
    localparam logic [2:0]        C_MUL_LAST   = 3'd7;

    localparam logic [14:0] C_QSINE [0:SINE_TABLE_ENTRIES-1] = '{
            15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,
            15'd2856,  15'd3425,  15'd3993,  15'd4560,  15'd5126,
            15'd5690,  15'd6252,  15'd6813,  15'd7371,  15'd7927,
            15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668,
            15'd11207, 15'd11743, 15'd12275, 15'd12803, 15'd13328,
            15'd13848, 15'd14364, 15'd14876, 15'd15383, 15'd15886,
            15'd16384, 15'd16876, 15'd17364, 15'd17846, 15'd18323,
            15'd18794, 15'd19260, 15'd19720, 15'd20173, 15'd20621,
            15'd21062, 15'd21497, 15'd21925, 15'd22347, 15'd22762,
            15'd23170, 15'd23571, 15'd23964, 15'd24351, 15'd24730,
            15'd25101, 15'd25465, 15'd25821, 15'd26169, 15'd26509,
            15'd26841, 15'd27165, 15'd27481, 15'd27788, 15'd28087,
            15'd28377, 15'd28659, 15'd28932, 15'd29196, 15'd29451,
            15'd29697, 15'd29934, 15'd30162, 15'd30381, 15'd30591,
            15'd30791, 15'd30982, 15'd31163, 15'd31335, 15'd31498,
            15'd31650, 15'd31794, 15'd31927, 15'd32051, 15'd32165,
            15'd32269, 15'd32364, 15'd32448, 15'd32523, 15'd32587,
            15'd32642, 15'd32687, 15'd32722, 15'd32747, 15'd32762,
            15'd32767
        };

    typedef struct packed {
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [31:0] focus_x;
        logic signed [31:0] focus_y;
        logic signed [31:0] focus_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [15:0] side_x;
        logic signed [15:0] side_z;
        logic signed [15:0] upv_x;
        logic signed [15:0] upv_y;
        logic signed [15:0] upv_z;
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP,
        S_TRIG,
        S_MUL,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_CPCY,
        OP_CPSY,
        OP_SPCY,
        OP_SPSY,
        OP_EYEX,
        OP_EYEY,
        OP_EYEZ
    } t_op;

    typedef struct packed {
        logic signed [16:0] a;
        logic signed [16:0] b;
        logic               eye;
    } t_mul_req;

    typedef struct packed {
        logic       done;
        logic [8:0] heading;
    } t_wrap_stat;

    function automatic logic signed [15:0] f_qsin(input logic [6:0] idx);
        logic [6:0] k;
        k = (idx > 7'(SINE_TABLE_ENTRIES - 1)) ? 7'(SINE_TABLE_ENTRIES - 1) : idx;
        return {1'b0, C_QSINE[k]};
    endfunction

    function automatic logic signed [15:0] f_sin_deg(input logic [8:0] h);
        logic [6:0] idx;
        logic       neg;
        if (h <= 9'd90) begin
            idx = h[6:0];
            neg = 1'b0;
        end else if (h <= 9'd180) begin
            idx = 7'(9'd180 - h);
            neg = 1'b0;
        end else if (h <= 9'd270) begin
            idx = 7'(h - 9'd180);
            neg = 1'b1;
        end else begin
            idx = 7'(9'd360 - h);
            neg = 1'b1;
        end
        return neg ? -f_qsin(idx) : f_qsin(idx);
    endfunction

    function automatic logic signed [15:0] f_cos_deg(input logic [8:0] h);
        logic [9:0] h2;
        h2 = {1'b0, h} + 10'd90;
        if (h2 >= 10'd360) begin
            h2 = h2 - 10'd360;
        end
        return f_sin_deg(h2[8:0]);
    endfunction

endpackage

FILE: src/orbit_camera_basis_update_core.sv
// Orbit camera basis update: an accepted item passes through the modulo-360
// heading reducer (one scaled subtract a cycle), the sine table lookups and
// the one shared multiplier (four Q1.15 basis products, three eye offsets, one
// drain), then is loaded into the output register once that is free. Input stall
// is high for the whole item; a finished result waits in the output register
// until it is taken.
// orbit_distance may be written any cycle and is sampled during the eye products.
module orbit_camera_basis_update_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  orbcam_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output orbcam_pkg::t_out_item o_out_item,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_wdata
);
    import orbcam_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [2:0]         r_cnt;
    logic               r_out_valid;
    t_out_item          r_out;
    logic [15:0]        r_orbit_distance;
    logic signed [15:0] r_last_x;
    logic signed [15:0] r_last_y;
    logic               r_mouse_seen;
    logic signed [7:0]  r_elev;
    logic [8:0]         r_heading;
    logic signed [31:0] r_focus_x;
    logic signed [31:0] r_focus_y;
    logic signed [31:0] r_focus_z;
    logic signed [15:0] r_sp;
    logic signed [15:0] r_cp;
    logic signed [15:0] r_sy;
    logic signed [15:0] r_cy;
    t_out_item          r_work;

    logic               accept;
    logic               load_out;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [17:0] h_sum;
    logic signed [17:0] e_sum;
    logic signed [7:0]  e_new;
    logic signed [17:0] wrap_in;
    t_wrap_stat         wrap_stat;
    logic [6:0]         e_abs;
    t_mul_req           mul_req;
    logic signed [26:0] mul_res;

    function automatic logic signed [31:0] f_eye(input logic signed [31:0] focus,
                                                 input logic signed [26:0] off);
        logic signed [32:0] s;
        s = {focus[31], focus} + {{6{off[26]}}, off};
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return s[31:0];
    endfunction

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        dx    = {r_last_x[15], r_last_x} - {i_in_item.mouse_x[15], i_in_item.mouse_x};
        dy    = {r_last_y[15], r_last_y} - {i_in_item.mouse_y[15], i_in_item.mouse_y};
        h_sum = {9'd0, r_heading} + {dx[16], dx};
        e_sum = {{10{r_elev[7]}}, r_elev} + {dy[16], dy};
        priority if (e_sum > 18'sd89) begin
            e_new = C_ELEV_LIMIT;
        end else if (e_sum < -18'sd89) begin
            e_new = -C_ELEV_LIMIT;
        end else begin
            e_new = e_sum[7:0];
        end
        wrap_in = r_mouse_seen ? h_sum : {9'd0, r_heading};
        e_abs   = r_elev[7] ? 7'(-r_elev) : r_elev[6:0];
    end

    orbcam_wrap u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_value (wrap_in),
        .o_stat  (wrap_stat)
    );

    always_comb begin
        mul_req = '0;
        case (t_op'(r_cnt))
            OP_CPCY: begin
                mul_req.a = {r_cp[15], r_cp};
                mul_req.b = {r_cy[15], r_cy};
            end
            OP_CPSY: begin
                mul_req.a = {r_cp[15], r_cp};
                mul_req.b = {r_sy[15], r_sy};
            end
            OP_SPCY: begin
                mul_req.a = {r_sp[15], r_sp};
                mul_req.b = {r_cy[15], r_cy};
            end
            OP_SPSY: begin
                mul_req.a = {r_sp[15], r_sp};
                mul_req.b = {r_sy[15], r_sy};
            end
            OP_EYEX: begin
                mul_req.a   = {r_work.dir_x[15], r_work.dir_x};
                mul_req.b   = {1'b0, r_orbit_distance};
                mul_req.eye = 1'b1;
            end
            OP_EYEY: begin
                mul_req.a   = {r_work.dir_y[15], r_work.dir_y};
                mul_req.b   = {1'b0, r_orbit_distance};
                mul_req.eye = 1'b1;
            end
            OP_EYEZ: begin
                mul_req.a   = {r_work.dir_z[15], r_work.dir_z};
                mul_req.b   = {1'b0, r_orbit_distance};
                mul_req.eye = 1'b1;
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    orbcam_mul u_mul (
        .i_clk (i_clk),
        .i_req (mul_req),
        .o_res (mul_res)
    );

    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                if (wrap_stat.done) begin
                    n_state = S_TRIG;
                end
            end
            S_TRIG: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (r_cnt == C_MUL_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_cnt            <= 3'd0;
            r_out_valid      <= 1'b0;
            r_orbit_distance <= C_DIST_RESET;
            r_last_x         <= '0;
            r_last_y         <= '0;
            r_mouse_seen     <= 1'b0;
            r_elev           <= C_ELEV_RESET;
            r_heading        <= C_HEAD_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == S_TRIG) begin
                r_cnt <= 3'd0;
            end else if (r_state == S_MUL) begin
                r_cnt <= r_cnt + 3'd1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_orbit_distance <= i_cfg_wdata;
            end
            if (accept) begin
                r_last_x     <= i_in_item.mouse_x;
                r_last_y     <= i_in_item.mouse_y;
                r_mouse_seen <= 1'b1;
                if (r_mouse_seen) begin
                    r_elev <= e_new;
                end
            end
            if (r_state == S_WRAP && wrap_stat.done) begin
                r_heading <= wrap_stat.heading;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_focus_x <= i_in_item.focus_x;
            r_focus_y <= i_in_item.focus_y;
            r_focus_z <= i_in_item.focus_z;
        end
        if (r_state == S_TRIG) begin
            r_sp          <= r_elev[7] ? -f_qsin(e_abs) : f_qsin(e_abs);
            r_cp          <= f_qsin(7'd90 - e_abs);
            r_sy          <= f_sin_deg(r_heading);
            r_cy          <= f_cos_deg(r_heading);
        end
        if (r_state == S_MUL) begin
            r_work.dir_y  <= r_sp;
            r_work.side_x <= r_sy;
            r_work.side_z <= -r_cy;
            r_work.upv_y  <= r_cp;
            if (r_cnt != 3'd0) begin
                case (t_op'(r_cnt - 3'd1))
                    OP_CPCY: r_work.dir_x <= mul_res[15:0];
                    OP_CPSY: r_work.dir_z <= mul_res[15:0];
                    OP_SPCY: r_work.upv_x <= -mul_res[15:0];
                    OP_SPSY: r_work.upv_z <= -mul_res[15:0];
                    OP_EYEX: r_work.eye_x <= f_eye(r_focus_x, mul_res);
                    OP_EYEY: r_work.eye_y <= f_eye(r_focus_y, mul_res);
                    OP_EYEZ: r_work.eye_z <= f_eye(r_focus_z, mul_res);
                    default: r_work.eye_z <= r_work.eye_z;
                endcase
            end
        end
        if (load_out) begin
            r_out <= r_work;
        end
    end

`ifndef SYNTHESIS
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heading < 9'd360)
        else $error("heading out of range");

    a_elev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_elev <= C_ELEV_LIMIT) && (r_elev >= -C_ELEV_LIMIT))
        else $error("elevation out of range");

    a_wrap_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wrap_stat.done |-> (r_state == S_WRAP))
        else $error("heading reducer finished outside its state");

    a_load_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !r_out_valid || $stable(r_out) || !$past(i_out_stall))
        else $error("pending result changed while stalled");
`endif

endmodule

FILE: src/orbcam_wrap.sv
// Heading reduction modulo 360: one compare-and-subtract of a scaled 360 per cycle.
// Depends on orbcam_pkg.
module orbcam_wrap (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [17:0]      i_value,
    output orbcam_pkg::t_wrap_stat  o_stat
);
    import orbcam_pkg::*;

    logic        r_busy;
    logic [2:0]  r_k;
    logic [16:0] r_val;
    logic [16:0] step;
    logic [16:0] n_val;

    always_comb begin
        step  = C_DEG_TURN << r_k;
        n_val = (r_val >= step) ? (r_val - step) : r_val;
    end

    assign o_stat.done    = r_busy && (r_k == 3'd0);
    assign o_stat.heading = n_val[8:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 3'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_k    <= C_WRAP_STEPS;
        end else if (r_busy) begin
            r_k <= r_k - 3'd1;
            if (r_k == 3'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value[17] ? 17'(i_value + {1'b0, C_WRAP_BIAS}) : i_value[16:0];
        end else if (r_busy) begin
            r_val <= n_val;
        end
    end

endmodule

FILE: src/orbcam_mul.sv
// Shared signed multiplier with registered product and round-half-away shift.
// Depends on orbcam_pkg.
module orbcam_mul (
    input  logic                  i_clk,
    input  orbcam_pkg::t_mul_req  i_req,
    output logic signed [26:0]    o_res
);
    import orbcam_pkg::*;

    logic signed [16:0] a;
    logic signed [16:0] b;
    logic signed [33:0] r_prod;
    logic               r_eye;
    logic signed [33:0] sum;
    logic signed [33:0] sh;

    assign a = i_req.a;
    assign b = i_req.b;

    always_ff @(posedge i_clk) begin
        r_prod <= a * b;
        r_eye  <= i_req.eye;
    end

    always_comb begin
        sum = r_prod + (r_eye ? 34'sd64 : 34'sd16384) - {33'd0, r_prod[33]};
        sh  = r_eye ? (sum >>> 7) : (sum >>> 15);
    end

    assign o_res = sh[26:0];

endmodule
